### src/tle_pkg.sv
// shared types and constants of the terminal line editor
package tle_pkg;

    localparam int KEY_W     = 8;
    localparam int COUNT_W   = 10;
    localparam int OUT_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [KEY_W-1:0] KEY_EOF     = 8'd4;
    localparam logic [KEY_W-1:0] KEY_LF      = 8'd10;
    localparam logic [KEY_W-1:0] KEY_CR      = 8'd13;
    localparam logic [KEY_W-1:0] KEY_WERASE  = 8'd23;
    localparam logic [KEY_W-1:0] KEY_SPACE   = 8'd32;
    localparam logic [KEY_W-1:0] KEY_TILDE   = 8'd126;
    localparam logic [KEY_W-1:0] ERASE_RESET = 8'd127;
    localparam logic [KEY_W-1:0] KILL_RESET  = 8'd21;

    localparam logic [CFG_IDX_W-1:0] CFG_ERASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL  = 2'd1;

    typedef enum logic [2:0] {
        ACT_ECHO    = 3'd0,
        ACT_ERASE   = 3'd1,
        ACT_NEWLINE = 3'd2,
        ACT_BELL    = 3'd3,
        ACT_END     = 3'd4
    } act_t;

    typedef enum logic [2:0] {
        KIND_NL     = 3'd0,
        KIND_ERASE  = 3'd1,
        KIND_KILL   = 3'd2,
        KIND_WERASE = 3'd3,
        KIND_PRINT  = 3'd4,
        KIND_OTHER  = 3'd5
    } kind_t;

    typedef struct packed {
        logic             is_eof;
        kind_t            kind;
        logic [KEY_W-1:0] key;
    } item_t;

endpackage

### src/tle_ram.sv
// generic single-write, single-read ram with registered read data
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/tle_fifo.sv
// two-entry queue of classified key items between front and back
module tle_fifo
    import tle_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/tle_front.sv
// input side: control byte registers and key classification
module tle_front
    import tle_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KEY_W-1:0]     s_tdata,    // key_byte
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output item_t                push_item
);

    logic [KEY_W-1:0] erase_reg, erase_next;
    logic [KEY_W-1:0] kill_reg, kill_next;
    kind_t            kind;

    assign cfg_ready  = 1'b1;
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb
    begin
        erase_next = erase_reg;
        kill_next  = kill_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ERASE: erase_next = cfg_data;
                CFG_KILL:  kill_next  = cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_reg <= ERASE_RESET;
            kill_reg  <= KILL_RESET;
        end
        else
        begin
            erase_reg <= erase_next;
            kill_reg  <= kill_next;
        end
    end

    // priority follows the editor's check order
    always_comb
    begin
        if (s_tdata == KEY_LF || s_tdata == KEY_CR)
        begin
            kind = KIND_NL;
        end
        else if (s_tdata == erase_reg)
        begin
            kind = KIND_ERASE;
        end
        else if (s_tdata == kill_reg)
        begin
            kind = KIND_KILL;
        end
        else if (s_tdata == KEY_WERASE)
        begin
            kind = KIND_WERASE;
        end
        else if (s_tdata >= KEY_SPACE && s_tdata <= KEY_TILDE)
        begin
            kind = KIND_PRINT;
        end
        else
        begin
            kind = KIND_OTHER;
        end
    end

    assign push_item.is_eof = (s_tdata == KEY_EOF);
    assign push_item.kind   = kind;
    assign push_item.key    = s_tdata;

endmodule

### src/tle_back.sv
// execution side: line store, edit sequencer and result register
module tle_back
    import tle_pkg::*;
#(
    parameter int BUF_DEPTH   = 1024,
    parameter int WRAP_COLUMN = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  item_t            pop_item,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // action, out_byte, erase_count, zero pad
    output logic             m_tlast    // last
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam logic [AW-1:0] ONE     = AW'(1);
    localparam logic [AW-1:0] ZERO    = AW'(0);
    localparam logic [AW-1:0] LEN_MAX = AW'(BUF_DEPTH - 1);
    localparam logic [AW-1:0] WRAP_L  = AW'(WRAP_COLUMN);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_WE     = 8'b0000_0010,
        ST_WE_OUT = 8'b0000_0100,
        ST_WSCAN  = 8'b0000_1000,
        ST_WECHO  = 8'b0001_0000,
        ST_WERS   = 8'b0010_0000,
        ST_WNL    = 8'b0100_0000,
        ST_MOVE   = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    len_reg, len_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [AW-1:0]    k_reg, k_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic             flag_reg, flag_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             ended_reg, ended_next;

    logic             ov_reg, ov_next;
    act_t             oact_reg, oact_next;
    logic [KEY_W-1:0] obyte_reg, obyte_next;
    logic [COUNT_W-1:0] ocnt_reg, ocnt_next;
    logic             olast_reg, olast_next;

    logic             out_free;
    logic             emit;
    act_t             e_act;
    logic [KEY_W-1:0] e_byte;
    logic [AW-1:0]    e_cnt;
    logic             e_last;
    logic [COUNT_W+AW-1:0] cnt_wide;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [KEY_W-1:0] wdata;
    logic [AW-1:0]    raddr;
    logic [KEY_W-1:0] rdata;
    logic [AW-1:0]    wlen;

    tle_ram #(
        .WIDTH (KEY_W),
        .DEPTH (BUF_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !ov_reg || m_tready;
    assign wlen     = len_reg - ptr_reg;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        flag_next  = flag_reg;
        key_next   = key_reg;
        ended_next = ended_reg;
        pop_ready  = 1'b0;
        emit       = 1'b0;
        e_act      = ACT_ECHO;
        e_byte     = '0;
        e_cnt      = ZERO;
        e_last     = 1'b0;
        we         = 1'b0;
        waddr      = len_reg;
        wdata      = pop_item.key;
        raddr      = len_reg - ONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && out_free)
                begin
                    pop_ready = 1'b1;
                    if (ended_reg)
                    begin
                        // session over: item is consumed silently
                    end
                    else if (pop_item.is_eof && len_reg == ZERO)
                    begin
                        emit       = 1'b1;
                        e_act      = ACT_END;
                        e_last     = 1'b1;
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        case (pop_item.kind)
                            KIND_NL:
                            begin
                                emit     = 1'b1;
                                e_act    = ACT_NEWLINE;
                                e_last   = 1'b1;
                                len_next = ZERO;
                            end
                            KIND_ERASE:
                            begin
                                emit   = 1'b1;
                                e_last = 1'b1;
                                if (len_reg != ZERO)
                                begin
                                    e_act    = ACT_ERASE;
                                    e_cnt    = ONE;
                                    len_next = len_reg - ONE;
                                end
                                else
                                begin
                                    e_act = ACT_BELL;
                                end
                            end
                            KIND_KILL:
                            begin
                                if (len_reg != ZERO)
                                begin
                                    emit     = 1'b1;
                                    e_act    = ACT_ERASE;
                                    e_cnt    = len_reg;
                                    e_last   = 1'b1;
                                    len_next = ZERO;
                                end
                            end
                            KIND_WERASE:
                            begin
                                if (len_reg == ZERO)
                                begin
                                    emit   = 1'b1;
                                    e_act  = ACT_BELL;
                                    e_last = 1'b1;
                                end
                                else
                                begin
                                    ptr_next   = len_reg;
                                    flag_next  = 1'b0;
                                    state_next = ST_WE;
                                end
                            end
                            KIND_PRINT:
                            begin
                                if (len_reg < LEN_MAX)
                                begin
                                    we       = 1'b1;
                                    len_next = len_reg + ONE;
                                    if (len_reg >= WRAP_L)
                                    begin
                                        ptr_next   = len_reg;
                                        key_next   = pop_item.key;
                                        state_next = ST_WSCAN;
                                    end
                                    else
                                    begin
                                        emit   = 1'b1;
                                        e_act  = ACT_ECHO;
                                        e_byte = pop_item.key;
                                        e_last = 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                emit   = 1'b1;
                                e_act  = ACT_BELL;
                                e_last = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_WE:
            begin
                // rdata holds the byte before ptr; trailing spaces, then one word
                if (ptr_reg == ZERO || (flag_reg && rdata == KEY_SPACE))
                begin
                    cnt_next   = len_reg - ptr_reg;
                    state_next = ST_WE_OUT;
                end
                else
                begin
                    if (rdata != KEY_SPACE)
                    begin
                        flag_next = 1'b1;
                    end
                    ptr_next = ptr_reg - ONE;
                end
                raddr = ptr_next - ONE;
            end
            ST_WE_OUT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_act      = ACT_ERASE;
                    e_cnt      = cnt_reg;
                    e_last     = 1'b1;
                    len_next   = ptr_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_WSCAN:
            begin
                if (ptr_reg == ZERO || wlen > WRAP_L)
                begin
                    flag_next  = 1'b0;
                    state_next = ST_WECHO;
                end
                else if (rdata == KEY_SPACE)
                begin
                    flag_next  = 1'b1;
                    state_next = ST_WECHO;
                end
                else
                begin
                    ptr_next = ptr_reg - ONE;
                end
                raddr = ptr_next - ONE;
            end
            ST_WECHO:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_act      = ACT_ECHO;
                    e_byte     = key_reg;
                    e_last     = !flag_reg;
                    state_next = flag_reg ? ST_WERS : ST_IDLE;
                end
            end
            ST_WERS:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_act      = ACT_ERASE;
                    e_cnt      = wlen;
                    cnt_next   = wlen;
                    state_next = ST_WNL;
                end
            end
            ST_WNL:
            begin
                raddr = ptr_reg;
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_act      = ACT_NEWLINE;
                    k_next     = ZERO;
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                // copy the word to the line start while echoing it
                if (out_free)
                begin
                    emit   = 1'b1;
                    e_act  = ACT_ECHO;
                    e_byte = rdata;
                    e_last = (k_reg == cnt_reg - ONE);
                    we     = 1'b1;
                    waddr  = k_reg;
                    wdata  = rdata;
                    if (k_reg == cnt_reg - ONE)
                    begin
                        len_next   = cnt_reg;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + ONE;
                    end
                end
                raddr = ptr_reg + k_next;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cnt_wide = {{COUNT_W{1'b0}}, e_cnt};

    always_comb
    begin
        ov_next    = ov_reg;
        oact_next  = oact_reg;
        obyte_next = obyte_reg;
        ocnt_next  = ocnt_reg;
        olast_next = olast_reg;
        if (emit)
        begin
            ov_next    = 1'b1;
            oact_next  = e_act;
            obyte_next = e_byte;
            ocnt_next  = cnt_wide[COUNT_W-1:0];
            olast_next = e_last;
        end
        else if (m_tready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            ended_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ended_reg <= ended_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
        flag_reg  <= flag_next;
        key_reg   <= key_next;
        oact_reg  <= oact_next;
        obyte_reg <= obyte_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {{(OUT_W - COUNT_W - KEY_W - 3){1'b0}}, ocnt_reg, obyte_reg, oact_reg};
    assign m_tlast  = olast_reg;

endmodule

### src/terminal_line_editor_wrap_core.sv
// top level of the canonical-mode terminal line editor with word wrap
//
// Each key byte goes into a two-entry queue after classification and is then
// carried out by the edit sequencer, which keeps the line in a BUF_DEPTH-byte
// store with one write and one registered read port and answers with echo
// actions, one per cycle while the output is taken and no scan is running.
// Echo, newline, erase, kill, bell and end of session are handled straight
// from the idle state. A word erase scans the store backward one byte per
// cycle. A printable byte past WRAP_COLUMN scans back at most WRAP_COLUMN+1
// bytes for the last word, then moves that word one byte per cycle while the
// output is taken. The store needs no clearing after reset. The control bytes
// for erase and kill are written over the cfg channel; the user must write them
// only while no key is in flight, as the block itself does not enforce it.
module terminal_line_editor_wrap_core
    import tle_pkg::*;
#(
    parameter int BUF_DEPTH   = 1024,
    parameter int WRAP_COLUMN = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KEY_W-1:0]     s_tdata,    // key_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,    // action, out_byte, erase_count, zero pad
    output logic                 m_tlast,    // last
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data
);

    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    tle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    tle_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    tle_back #(
        .BUF_DEPTH   (BUF_DEPTH),
        .WRAP_COLUMN (WRAP_COLUMN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
